FILE: rtl/ltm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltm_pkg: shared types and constants for the layer trapezoid mean unit
// Payload structs for the sample and result channels, register indexes.
// ----------------------------------------------------------------------------
package ltm_pkg;

  localparam int PRESS_W = 20;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 20;

  localparam logic CFG_IDX_TOP    = 1'b0;
  localparam logic CFG_IDX_BOTTOM = 1'b1;

  typedef struct packed {
    logic [PRESS_W-1:0]        pressure;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      first_sample;
    logic                      last_sample;
  } ltm_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] layer_mean;
    logic                      mean_valid;
  } ltm_out_t;

endpackage

FILE: rtl/layer_trapezoid_mean_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_trapezoid_mean_unit: layer mean of a profile by the trapezoidal rule
// Channel | dir | handshake        | payload
// in_     | in  | in_valid/stall   | ltm_in_t  (pressure, value, first, last)
// out_    | out | out_valid/stall  | ltm_out_t (layer_mean, mean_valid)
// cfg_    | in  | cfg_we           | layer_top (0), layer_bottom (1)
// A valid sample inside the layer takes two endpoint interpolations, each a
// pass of the one shared divider, plus multiplies; the final mean takes
// another division. Reset is synchronous and clears the profile state. The
// result sits in an output register; a stalled result holds the sequencer.
// ----------------------------------------------------------------------------
module layer_trapezoid_mean_unit
  import ltm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ltm_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ltm_out_t         out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SEG   = 4'd1;
  localparam logic [3:0] S_M0    = 4'd2;
  localparam logic [3:0] S_M1    = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_DWAIT = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_ACC2  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_FWAIT = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]  state_r, state_nxt;
  logic [19:0] top_r, bot_r;
  logic [19:0] pp_r, pp_nxt;
  logic [31:0] pv_r, pv_nxt;
  logic        hp_r, hp_nxt, tr_r, tr_nxt, br_r, br_nxt;
  logic [63:0] ws_r, ws_nxt;
  logic [31:0] ts_r, ts_nxt;
  logic [19:0] p_r, p_nxt;
  logic [31:0] v_r, v_nxt;
  logic        last_r, last_nxt;
  logic [19:0] a_r, a_nxt, b_r, b_nxt;
  logic        side_r, side_nxt;
  logic [31:0] va_r, va_nxt, vb_r, vb_nxt;
  logic [52:0] m0_r, m0_nxt, m1_r, m1_nxt;
  logic [32:0] mq_a, mq_b;
  logic [19:0] md_a, md_b;
  logic [52:0] prod;
  logic [19:0] x_pt;
  logic [19:0] seg_a, seg_b;
  logic        div_start, div_busy;
  logic [63:0] div_dvd, div_q;
  logic [41:0] div_dvs;
  ltm_out_t    out_r, out_nxt;
  logic        ov_r, ov_nxt;
  logic        mean_ok;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
      bot_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_TOP) begin
        top_r <= cfg_data;
      end else begin
        bot_r <= cfg_data;
      end
    end
  end

  ltm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // clipped segment ends and the shared multiplier operands
  assign seg_a = (pp_r > top_r) ? pp_r : top_r;
  assign seg_b = (p_r < bot_r) ? p_r : bot_r;
  assign x_pt  = side_r ? b_r : a_r;
  always_comb begin
    mq_a = {1'b0, pv_r};
    md_a = p_r - x_pt;
    if (state_r == S_M1) begin
      mq_a = {1'b0, v_r};
      md_a = x_pt - pp_r;
    end else if (state_r == S_ACC2) begin
      // trapezoid area: endpoint sum times clipped span
      mq_a = m0_r[32:0];
      md_a = b_r - a_r;
    end
    mq_b = mq_a;
    md_b = md_a;
  end
  assign prod = {20'd0, mq_b} * {33'd0, md_b};
  assign mean_ok = tr_r && br_r && (ts_r != '0);

  always_comb begin
    state_nxt = state_r;
    pp_nxt = pp_r; pv_nxt = pv_r; hp_nxt = hp_r; tr_nxt = tr_r; br_nxt = br_r;
    ws_nxt = ws_r; ts_nxt = ts_r;
    p_nxt = p_r; v_nxt = v_r; last_nxt = last_r;
    a_nxt = a_r; b_nxt = b_r; side_nxt = side_r;
    va_nxt = va_r; vb_nxt = vb_r; m0_nxt = m0_r; m1_nxt = m1_r;
    out_nxt = out_r; ov_nxt = ov_r;
    div_start = 1'b0;
    div_dvd = '0;
    div_dvs = '0;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          p_nxt    = in_data.pressure;
          v_nxt    = in_data.sample_value;
          last_nxt = in_data.last_sample;
          if (in_data.first_sample) begin
            pp_nxt = '0; pv_nxt = '0; hp_nxt = 1'b0; tr_nxt = 1'b0;
            br_nxt = 1'b0; ws_nxt = '0; ts_nxt = '0;
          end
          state_nxt = S_SEG;
          if (in_data.first_sample && in_data.sample_value[31]) begin
            state_nxt = S_FIN;
          end
        end
      end
      // bracketing checks and segment clipping
      S_SEG: begin
        state_nxt = S_FIN;
        if (!v_r[31]) begin
          if (hp_r && p_r >= pp_r) begin
            if (pp_r <= top_r && top_r <= p_r) tr_nxt = 1'b1;
            if (pp_r <= bot_r && bot_r <= p_r) br_nxt = 1'b1;
            a_nxt = seg_a;
            b_nxt = seg_b;
            side_nxt = 1'b0;
            if (p_r != pp_r && seg_a < seg_b) begin
              state_nxt = S_M0;
            end
          end
          if (state_nxt == S_FIN) begin
            pp_nxt = p_r; pv_nxt = v_r; hp_nxt = 1'b1;
          end
        end
      end
      S_M0: begin
        m0_nxt = prod;
        state_nxt = S_M1;
      end
      S_M1: begin
        m1_nxt = prod;
        state_nxt = S_DIV;
      end
      // (2*num + d) / (2*d)
      S_DIV: begin
        div_start = 1'b1;
        div_dvd = {10'd0, m0_r + m1_r, 1'b0} + {44'd0, p_r - pp_r};
        div_dvs = {21'd0, p_r - pp_r, 1'b0};
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (!div_busy && !div_start) begin
          if (!side_r) begin
            va_nxt = div_q[31:0];
            side_nxt = 1'b1;
            state_nxt = S_M0;
          end else begin
            vb_nxt = div_q[31:0];
            state_nxt = S_ACC;
          end
        end
      end
      S_ACC: begin
        m0_nxt = ({21'd0, va_r} + {21'd0, vb_r});
        state_nxt = S_ACC2;
      end
      S_ACC2: begin
        ws_nxt = ws_r + {11'd0, prod};
        ts_nxt = ts_r + {12'd0, b_r - a_r};
        pp_nxt = p_r; pv_nxt = v_r; hp_nxt = 1'b1;
        state_nxt = S_FIN;
      end
      // end of sample: maybe start the mean division
      S_FIN: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (mean_ok) begin
          div_start = 1'b1;
          div_dvd = ws_r + {32'd0, ts_r};
          div_dvs = {9'd0, ts_r, 1'b0};
          state_nxt = S_FWAIT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_FWAIT: begin
        if (!div_busy && !div_start) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_nxt) begin
          out_nxt.mean_valid = mean_ok;
          out_nxt.layer_mean = '0;
          if (mean_ok) begin
            out_nxt.layer_mean = (div_q[63:31] != '0) ? 32'h7FFF_FFFF : div_q[31:0];
          end
          ov_nxt = 1'b1;
          pp_nxt = '0; pv_nxt = '0; hp_nxt = 1'b0; tr_nxt = 1'b0;
          br_nxt = 1'b0; ws_nxt = '0; ts_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      hp_r <= 1'b0; tr_r <= 1'b0; br_r <= 1'b0;
      pp_r <= '0; pv_r <= '0; ws_r <= '0; ts_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      hp_r <= hp_nxt; tr_r <= tr_nxt; br_r <= br_nxt;
      pp_r <= pp_nxt; pv_r <= pv_nxt; ws_r <= ws_nxt; ts_r <= ts_nxt;
    end
    p_r <= p_nxt; v_r <= v_nxt; last_r <= last_nxt;
    a_r <= a_nxt; b_r <= b_nxt; side_r <= side_nxt;
    va_r <= va_nxt; vb_r <= vb_nxt; m0_r <= m0_nxt; m1_r <= m1_nxt;
    out_r <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/ltm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltm_divider: radix-2 restoring divider
// Unsigned 64-bit dividend by 42-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ltm_divider
  import ltm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [41:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);

  logic [63:0] quot_r, quot_nxt;
  logic [41:0] rem_r, rem_nxt;
  logic [41:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [42:0] shifted;
  logic [43:0] diff;

  // one shift-subtract step
  assign shifted = {rem_r, quot_r[63]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so 42 bits hold it
      if (!diff[43]) begin
        rem_nxt  = diff[41:0];
        quot_nxt = {quot_r[62:0], 1'b1};
      end else begin
        rem_nxt  = shifted[41:0];
        quot_nxt = {quot_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quot_r;

endmodule

FILE: rtl/ltm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltm_checker: port-level checks for the layer trapezoid mean unit
// Watches the handshakes and result encoding; bound to the top level.
// ----------------------------------------------------------------------------
module ltm_checker
  import ltm_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input ltm_out_t out_data
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // an invalid mean reads as zero
  a_zero_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.mean_valid |-> out_data.layer_mean == '0)
    else $error("invalid result carries a nonzero mean");

  // a mean is never negative
  a_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.layer_mean[31])
    else $error("negative mean");

  // a transfer on the input is followed by a busy cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("sample taken without work cycle");

endmodule

bind layer_trapezoid_mean_unit ltm_checker u_ltm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: verif/layer_trapezoid_mean_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_trapezoid_mean_unit_tb: self-checking bench for the layer mean unit
// Drives profiles of samples through the valid/stall channel under several
// idle and stall mixes, predicts each trapezoidal layer mean and compares
// every result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module layer_trapezoid_mean_unit_tb
  import ltm_pkg::*;
();

  localparam int  DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ltm_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ltm_out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_IDX_TOP;
  logic [CFG_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  layer_trapezoid_mean_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: layer bounds and the running profile integral
  logic [19:0] bound_top, bound_bot;
  logic [19:0] last_press;
  logic [31:0] last_val;
  logic        have_last, top_hit, bot_hit;
  logic [63:0] area2_sum;
  logic [31:0] span_sum;

  ltm_out_t mean_q[$];
  int  error_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_recv = 1'b0;
  longint cycle_count = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("MISMATCH %s: got %h expected %h", what, got, exp);
    error_count++;
  endtask

  function automatic void clear_profile_state();
    last_press = '0; last_val = '0; have_last = 1'b0;
    top_hit = 1'b0; bot_hit = 1'b0; area2_sum = '0; span_sum = '0;
  endfunction

  function automatic logic [31:0] line_value(logic [19:0] p0, logic [31:0] v0,
      logic [19:0] p1, logic [31:0] v1, logic [19:0] x);
    logic [63:0] d, num;
    d = 64'(p1 - p0);
    num = 64'(v0) * 64'(p1 - x) + 64'(v1) * 64'(x - p0);
    return 32'((2 * num + d) / (2 * d));
  endfunction

  function automatic void add_piece(logic [19:0] p0, logic [31:0] v0,
                                    logic [19:0] p1, logic [31:0] v1);
    logic [19:0] a, b;
    logic [31:0] va, vb;
    if (p1 < p0) return;
    if (p0 <= bound_top && bound_top <= p1) top_hit = 1'b1;
    if (p0 <= bound_bot && bound_bot <= p1) bot_hit = 1'b1;
    if (p1 == p0) return;
    a = (p0 > bound_top) ? p0 : bound_top;
    b = (p1 < bound_bot) ? p1 : bound_bot;
    if (a >= b) return;
    va = line_value(p0, v0, p1, v1, a);
    vb = line_value(p0, v0, p1, v1, b);
    area2_sum += (64'(va) + 64'(vb)) * 64'(b - a);
    span_sum += 32'(b - a);
  endfunction

  // Returns 1 and the expected result when the sample closes a profile
  function automatic bit predict_mean(ltm_in_t s, output ltm_out_t r);
    logic [63:0] t, m;
    r = '0;
    if (s.first_sample) clear_profile_state();
    if (!s.sample_value[31]) begin
      if (have_last) add_piece(last_press, last_val, s.pressure, s.sample_value);
      last_press = s.pressure; last_val = s.sample_value; have_last = 1'b1;
    end
    if (!s.last_sample) return 0;
    r.mean_valid = top_hit && bot_hit && span_sum != 0;
    if (r.mean_valid) begin
      t = 64'(span_sum);
      m = (area2_sum + t) / (2 * t);
      if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
      r.layer_mean = m[31:0];
    end
    clear_profile_state();
    return 1;
  endfunction

  task automatic write_reg(input logic idx, input logic [19:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_TOP) bound_top = val; else bound_bot = val;
  endtask

  // One transfer on the sample channel; predictions queued at acceptance.
  // Valid stays up after the transfer until the next call or a drain.
  task automatic send_sample(input ltm_in_t s);
    ltm_out_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; in_data <= s;
    do @(posedge clk); while (in_stall);
    if (predict_mean(s, r)) mean_q.push_back(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000 | $urandom;             // missing
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom & 32'h7FFF_FFFF;
      default: return $urandom_range(32'h00FF_FFFF);
    endcase
  endfunction

  // Profile: rising pressures around the layer with occasional noise, random content
  task automatic send_profile(input int n);
    ltm_in_t s;
    logic [19:0] p;
    int step;
    step = $urandom_range(1, 3) == 1 ? $urandom_range(1, 20) : $urandom_range(1, 4000);
    p = (bound_top > 20'(step * 2)) ? bound_top - 20'($urandom_range(0, step * 2)) :
        20'($urandom_range(0, bound_top));
    for (int i = 0; i < n; i++) begin
      s.pressure = p;
      s.sample_value = rand_value();
      s.first_sample = (i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(99) == 0);
      s.last_sample = (i == n - 1);
      if ($urandom_range(29) == 0) s.pressure = 20'($urandom);  // noise
      send_sample(s);
      if (p > 20'hFFFFF - 20'(step)) p = 20'hFFFFF;
      else p = p + 20'($urandom_range(0, step));
    end
  endtask

  // Directed rows: pressure, value, first, last, check-fixed, fixed result
  typedef struct {
    ltm_in_t  s;
    bit       fixed;
    ltm_out_t r;
  } row_t;

  row_t rows[$];

  function automatic row_t mk(logic [19:0] p, logic [31:0] v, bit f, bit l,
                              bit fixed = 0, logic [31:0] m = 0, bit ok = 0);
    row_t x;
    x.s.pressure = p; x.s.sample_value = v; x.s.first_sample = f; x.s.last_sample = l;
    x.fixed = fixed; x.r.layer_mean = m; x.r.mean_valid = ok;
    return x;
  endfunction

  // Result checker and stall generator
  always @(posedge clk) begin
    ltm_out_t e;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (mean_q.size() == 0) begin
        report_mismatch("unexpected result", out_data.layer_mean, 0);
      end else begin
        e = mean_q.pop_front();
        if (out_data.mean_valid !== e.mean_valid)
          report_mismatch("mean_valid", out_data.mean_valid, e.mean_valid);
        if (out_data.layer_mean !== e.layer_mean)
          report_mismatch("layer_mean", out_data.layer_mean, e.layer_mean);
      end
    end
    out_stall <= hold_recv || (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("layer_trapezoid_mean_unit_tb failed");
      $finish;
    end
  end

  initial begin
    row_t x;
    bound_top = '0; bound_bot = '0;
    clear_profile_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset both bounds are zero: zero thickness, never valid
    rows.push_back(mk(20'd0, 32'h0001_0000, 1, 0));
    rows.push_back(mk(20'd10, 32'h0002_0000, 0, 1, 1, 0, 0));
    foreach (rows[i]) begin
      x = rows[i];
      send_sample(x.s);
      if (x.fixed) mean_q[$] = x.r;
    end
    wait_drained();

    write_reg(CFG_IDX_TOP, 20'd100);
    write_reg(CFG_IDX_BOTTOM, 20'd200);
    rows.delete();
    // constant profile spanning the layer: mean equals the value
    rows.push_back(mk(20'd0, 32'h0003_0000, 1, 0));
    rows.push_back(mk(20'd300, 32'h0003_0000, 0, 1, 1, 32'h0003_0000, 1));
    // missing sample skipped, missing last still ends the profile
    rows.push_back(mk(20'd50, 32'h0001_0000, 1, 0));
    rows.push_back(mk(20'd120, 32'hFFFF_FFFF, 0, 0));
    rows.push_back(mk(20'd250, 32'h0001_0000, 0, 0));
    rows.push_back(mk(20'd260, 32'h8000_0000, 0, 1, 1, 32'h0001_0000, 1));
    // bottom not bracketed: invalid
    rows.push_back(mk(20'd0, 32'h0001_0000, 1, 0));
    rows.push_back(mk(20'd150, 32'h0001_0000, 0, 1, 1, 0, 0));
    // no valid samples at all
    rows.push_back(mk(20'd0, 32'hFFFF_0000, 1, 1, 1, 0, 0));
    // falling pressure, then interpolated ramp; no first after a result
    rows.push_back(mk(20'd90, 32'h0000_0000, 0, 0));
    rows.push_back(mk(20'd40, 32'h0010_0000, 0, 0));
    rows.push_back(mk(20'd130, 32'h0000_0007, 0, 0));
    rows.push_back(mk(20'd130, 32'h7FFF_FFFF, 0, 0));
    rows.push_back(mk(20'd230, 32'h0000_0001, 0, 1));
    // equal pressures on the bounds bracket them
    rows.push_back(mk(20'd100, 32'h7FFF_FFFF, 1, 0));
    rows.push_back(mk(20'd200, 32'h7FFF_FFFF, 0, 1, 1, 32'h7FFF_FFFF, 1));
    foreach (rows[i]) begin
      x = rows[i];
      send_sample(x.s);
      if (x.fixed) mean_q[$] = x.r;
    end
    wait_drained();

    // Extreme bounds: full pressure range, top above bottom
    write_reg(CFG_IDX_TOP, 20'd0);
    write_reg(CFG_IDX_BOTTOM, 20'hFFFFF);
    send_sample(mk(20'd0, 32'h7FFF_FFFF, 1, 0).s);
    send_sample(mk(20'hFFFFF, 32'h0, 0, 1).s);
    wait_drained();
    write_reg(CFG_IDX_TOP, 20'hFFFFF);
    write_reg(CFG_IDX_BOTTOM, 20'd5);
    send_sample(mk(20'd0, 32'h1, 1, 0).s);
    send_sample(mk(20'hFFFFF, 32'h1, 0, 1).s);
    wait_drained();

    // Receiver holds off while samples keep coming
    write_reg(CFG_IDX_TOP, 20'd10);
    write_reg(CFG_IDX_BOTTOM, 20'd40);
    fork
      begin
        hold_recv = 1'b1;
        repeat (3000) @(posedge clk);
        hold_recv = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_profile(2);
    join
    wait_drained();

    // Random phases under different idle mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      case ($urandom_range(3))
        0: begin write_reg(CFG_IDX_TOP, 20'($urandom)); write_reg(CFG_IDX_BOTTOM, 20'($urandom)); end
        1: begin write_reg(CFG_IDX_TOP, 20'd0); write_reg(CFG_IDX_BOTTOM, 20'($urandom_range(1, 5000))); end
        2: begin write_reg(CFG_IDX_TOP, 20'hFFFF0); write_reg(CFG_IDX_BOTTOM, 20'hFFFFF); end
        default: begin
          write_reg(CFG_IDX_TOP, 20'($urandom_range(0, 900000)));
          write_reg(CFG_IDX_BOTTOM, bound_top + 20'($urandom_range(0, 3000)));
        end
      endcase
      for (int k = 0; k < 175 / 4; k++) begin
        if ($urandom_range(9) == 0) send_sample(ltm_in_t'(54'({$urandom, $urandom})));
        else send_profile($urandom_range(1, 7));
      end
      wait_drained();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    wait_drained();

    if (error_count == 0)
      $display("layer_trapezoid_mean_unit_tb passed");
    else
      $display("layer_trapezoid_mean_unit_tb failed");
    $finish;
  end

endmodule
